// ----- sv/f2mfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package f2mfe_pkg;

  localparam int unsigned FLOAT_W  = 32;
  localparam int unsigned FRAC_W   = 23;
  localparam int unsigned BEXP_W   = 8;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  // Register map: index i sits at byte address 4*i
  typedef enum logic [1:0] {
    REG_EXP_BITS    = 2'd0,
    REG_SIG_BITS    = 2'd1,
    REG_DENORM_BIAS = 2'd2
  } reg_idx_e;

  localparam logic [3:0]        EXP_BITS_RST    = 4'd5;
  localparam logic [4:0]        SIG_BITS_RST    = 5'd10;
  localparam logic signed [7:0] DENORM_BIAS_RST = -8'sd15;

  typedef struct packed {
    logic [3:0]        exp_w;
    logic [4:0]        sig_bits;
    logic signed [7:0] denorm_bias;
  } cfg_t;

endpackage

`default_nettype wire

// ----- sv/f2mfe_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface f2mfe_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink   (input valid, input float_bits, output ready);
endinterface

interface f2mfe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_value;

  modport source (output valid, output packed_value, input ready);
  modport sink   (input valid, input packed_value, output ready);
endinterface

`default_nettype wire

// ----- sv/float32_to_minifloat_encoder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Float32 to minifloat encoder.
// in_i carries one raw IEEE single per item (float_bits); out_o returns one
// packed word per item (packed_value): sign, exponent field, significand.
// Both are valid/ready channels; an item moves when valid and ready are high.
// Field widths and the denormal threshold are set over the APB port
// (0x0 exponent width, 0x4 significand width, 0x8 denormal bias); write
// them only while no item is in flight. Reads return the register values.
// The item is registered at the input, converted in one pass of
// shift/round logic, and lands in the output register. Throughput is
// 1 item per cycle while out_o is ready. When the receiver stalls, the output
// register holds its word and the input register still takes one more
// item; ready drops only when both registers are full and out_o is stalled.
// Reset clears both valid flags and loads widths 5/10 and bias -15.

module float32_to_minifloat_encoder_core import f2mfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  f2mfe_in_if.sink          in_i,
  f2mfe_out_if.source       out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t               cfg;
  logic               in_vld_q;
  logic               in_vld_d;
  logic               out_vld_q;
  logic               out_vld_d;
  logic [FLOAT_W-1:0] float_bits_q;
  logic [FLOAT_W-1:0] packed_value_q;
  logic [FLOAT_W-1:0] conv_value;
  logic               in_adv;
  logic               out_free;

  f2mfe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  f2mfe_conv u_conv (
    .float_bits_i   (float_bits_q),
    .cfg_i          (cfg),
    .packed_value_o (conv_value)
  );

  assign out_free   = !out_vld_q || out_o.ready;
  assign in_adv     = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || in_adv;

  assign in_vld_d  = in_i.ready ? in_i.valid : in_vld_q;
  assign out_vld_d = out_free ? in_vld_q : out_vld_q;

  assign out_o.valid        = out_vld_q;
  assign out_o.packed_value = packed_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      float_bits_q <= in_i.float_bits;
    end
    if (in_adv) begin
      packed_value_q <= conv_value;
    end
  end

  // an item in the input register moves on when the output register is empty
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_vld_q |=> out_vld_q)
    else $error("input register item not forwarded");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q))
    else $error("result appeared without an input item");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !out_o.ready |=> in_vld_q && $stable(float_bits_q))
    else $error("input register changed while pipeline stalled");

endmodule

`default_nettype wire

// ----- sv/f2mfe_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module f2mfe_cfg import f2mfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_EXP_BITS:    cfg_d.exp_w       = pwdata[3:0];
        REG_SIG_BITS:    cfg_d.sig_bits    = pwdata[4:0];
        REG_DENORM_BIAS: cfg_d.denorm_bias = $signed(pwdata[7:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EXP_BITS:    prdata = {28'b0, cfg_q.exp_w};
      REG_SIG_BITS:    prdata = {27'b0, cfg_q.sig_bits};
      REG_DENORM_BIAS: prdata = {{24{cfg_q.denorm_bias[7]}}, cfg_q.denorm_bias};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.exp_w       <= EXP_BITS_RST;
      cfg_q.sig_bits    <= SIG_BITS_RST;
      cfg_q.denorm_bias <= DENORM_BIAS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/f2mfe_conv.sv -----
`timescale 1ns / 1ps
`default_nettype none

module f2mfe_conv import f2mfe_pkg::*; (
  input  logic [FLOAT_W-1:0] float_bits_i,
  input  cfg_t               cfg_i,
  output logic [FLOAT_W-1:0] packed_value_o
);

  logic                sign_b;
  logic [BEXP_W-1:0]   biased;
  logic [FRAC_W-1:0]   frac;
  logic [5:0]          sign_pos;
  logic [31:0]         sign_w;
  logic signed [9:0]   x0;
  logic signed [9:0]   x1;
  logic signed [9:0]   d10;
  logic signed [9:0]   dmx;   // d - x
  logic signed [9:0]   xmd;   // x - d
  logic [31:0]         r0;
  logic [31:0]         r1;
  logic [31:0]         r2;
  logic [31:0]         ra;
  logic [31:0]         rb;
  logic [31:0]         rc;
  logic [31:0]         rd;
  logic [31:0]         r_res;
  logic [31:0]         carry_mask;
  logic [31:0]         s_mask;
  logic [31:0]         ones_s;
  logic [15:0]         ones_e;
  logic [15:0]         pow_e;
  logic [15:0]         field;
  logic signed [16:0]  ovf_lim;
  logic                rnd;
  logic                bump;
  logic                ovf;

  always_comb begin
    sign_b = float_bits_i[31];
    biased = float_bits_i[30:23];
    frac   = float_bits_i[22:0];

    // sign position past bit 31 drops the sign
    sign_pos = {2'b0, cfg_i.exp_w} + {1'b0, cfg_i.sig_bits};
    sign_w   = {31'b0, sign_b} << sign_pos;

    x0  = $signed({2'b0, biased}) - 10'sd127;
    d10 = {{2{cfg_i.denorm_bias[7]}}, cfg_i.denorm_bias};

    // fraction aligned to s+1 bits
    if (cfg_i.sig_bits <= 5'd22) begin
      r0 = {9'b0, frac} >> (5'd22 - cfg_i.sig_bits);
    end else begin
      r0 = {9'b0, frac} << (cfg_i.sig_bits - 5'd22);
    end

    // normal rounding, carry into bit s+1 bumps the exponent
    rnd        = (x0 > d10) && r0[0];
    r1         = r0 + {31'b0, rnd};
    carry_mask = 32'd1 << ({1'b0, cfg_i.sig_bits} + 6'd1);
    bump       = |(r1 & carry_mask);
    x1         = x0 + $signed({9'b0, bump});
    r2         = (r1 & ~carry_mask) >> 1;

    s_mask = 32'd1 << cfg_i.sig_bits;
    ones_s = ~(32'hFFFF_FFFF << cfg_i.sig_bits);
    ones_e = ~(16'hFFFF << cfg_i.exp_w);
    pow_e  = 16'd1 << cfg_i.exp_w;

    // threshold case
    ra = r2 + {31'b0, r2[0]};

    // below threshold: hidden one, align, round
    dmx = d10 - x1;
    rb  = r2 | s_mask;
    rc  = rb >> dmx;
    rd  = rc + {31'b0, rc[0]};

    ovf_lim = $signed({1'b0, pow_e}) + {{7{d10[9]}}, d10};
    ovf     = $signed({{7{x1[9]}}, x1}) >= ovf_lim;
    xmd     = x1 - d10;

    if (biased == 8'hFF) begin
      field = ones_e;
      r_res = ones_s;
    end else if (x1 == d10) begin
      if (|(ra & s_mask)) begin
        r_res = ra & ~s_mask;
        field = 16'd1;
      end else begin
        r_res = (ra | s_mask) >> 1;
        field = 16'd0;
      end
    end else if (x1 < d10) begin
      r_res = rd >> 1;
      field = 16'd0;
    end else if (ovf) begin
      field = ones_e;
      r_res = ones_s;
    end else begin
      r_res = r2;
      field = {6'b0, xmd};
    end

    packed_value_o = sign_w | ({16'b0, field} << cfg_i.sig_bits) | r_res;
  end

endmodule

`default_nettype wire

// ----- verif/tb_float32_to_minifloat_encoder_core.sv -----
`timescale 1ns / 1ps

module tb_float32_to_minifloat_encoder_core;
  import f2mfe_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned MAX_REPORTS   = 100;
  localparam logic [1:0]  REG_UNMAPPED  = 2'd3;

  typedef struct {
    logic [31:0] float_bits;
    logic [31:0] packed_value;
  } packed_due_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  f2mfe_in_if  in_if ();
  f2mfe_out_if out_if ();

  float32_to_minifloat_encoder_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the format registers
  logic [3:0]        exp_w_m    = EXP_BITS_RST;
  logic [4:0]        sig_bits_m = SIG_BITS_RST;
  logic signed [7:0] bias_m     = DENORM_BIAS_RST;

  packed_due_t packed_due_q[$];
  packed_due_t want;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_en   = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sh_left(logic [31:0] v, int unsigned n);
    return (n >= 32) ? 32'd0 : (v << n);
  endfunction

  function automatic logic [31:0] sh_right(logic [31:0] v, int unsigned n);
    return (n >= 32) ? 32'd0 : (v >> n);
  endfunction

  function automatic logic [31:0] low_mask(int unsigned n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  function automatic logic [31:0] encode_minifloat(logic [31:0] f);
    int unsigned ew;
    int unsigned sw;
    int          thr;
    int          x;
    logic [31:0] sgn;
    logic [31:0] r;
    logic [31:0] fld;
    ew  = exp_w_m;
    sw  = sig_bits_m;
    thr = bias_m;
    x   = int'(f[30:23]) - 127;
    sgn = sh_left({31'd0, f[31]}, ew + sw);
    if (sw <= 22) r = {9'd0, f[22:0]} >> (22 - sw);
    else          r = sh_left({9'd0, f[22:0]}, sw - 22);
    // r carries one extra round bit below the kept significand
    if (x > thr && r[0]) begin
      r = r + 32'd1;
      if ((r & sh_left(32'd1, sw + 1)) != 32'd0) begin
        x++;
        r = r & ~sh_left(32'd1, sw + 1);
      end
    end
    r = r >> 1;
    if (f[30:23] == 8'hFF) begin
      fld = low_mask(ew);
      r   = low_mask(sw);
    end else if (x == thr) begin
      if (r[0]) r = r + 32'd1;
      if ((r & sh_left(32'd1, sw)) != 32'd0) begin
        r   = r & ~sh_left(32'd1, sw);
        fld = 32'd1;
      end else begin
        r   = (r | sh_left(32'd1, sw)) >> 1;
        fld = 32'd0;
      end
    end else if (x < thr) begin
      r = sh_right(r | sh_left(32'd1, sw), thr - x);
      if (r[0]) r = r + 32'd1;
      r   = r >> 1;
      fld = 32'd0;
    end else if (longint'(x) >= longint'(sh_left(32'd1, ew)) + longint'(thr)) begin
      fld = low_mask(ew);
      r   = low_mask(sw);
    end else begin
      fld = 32'(x - thr);
    end
    return sgn | sh_left(fld, sw) | r;
  endfunction

  // Exponents are steered toward the denormal threshold and the overflow edge
  function automatic logic [31:0] rand_float();
    int          thr;
    int          sw;
    int          bexp;
    logic [22:0] frac;
    thr = bias_m;
    thr = thr + 127;
    sw  = sig_bits_m;
    case ($urandom_range(0, 5))
      0:       bexp = $urandom_range(0, 255);
      1:       bexp = thr - sw - 4 + int'($urandom_range(0, sw + 6));
      2:       bexp = thr + (1 << exp_w_m) - 3 + int'($urandom_range(0, 4));
      3:       bexp = $urandom_range(0, 1) ? 255 : 0;
      default: bexp = thr + int'($urandom_range(0, 1 << exp_w_m));
    endcase
    if (bexp < 0)   bexp = 0;
    if (bexp > 255) bexp = 255;
    if ($urandom_range(0, 3) == 0) frac = 23'h7F_FFFF << $urandom_range(0, 23);
    else                           frac = 23'($urandom);
    return {1'($urandom), 8'(bexp), frac};
  endfunction

  // the bus returns to idle after each transfer, keeping back-to-back writes apart
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_EXP_BITS:    exp_w_m    = value[3:0];
      REG_SIG_BITS:    sig_bits_m = value[4:0];
      REG_DENORM_BIAS: bias_m     = value[7:0];
      default: ;
    endcase
  endtask

  // valid stays high after an accept so that back-to-back items need no
  // second assignment in the same step
  task automatic send_float(input logic [31:0] f);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.float_bits <= f;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    packed_due_q.push_back('{f, encode_minifloat(f)});
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (packed_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_format(input int e, input int s, input int d, input int n);
    wait_drained();
    write_reg(REG_EXP_BITS, 32'(e));
    write_reg(REG_SIG_BITS, 32'(s));
    write_reg(REG_DENORM_BIAS, {24'd0, 8'(d)});
    repeat (n) send_float(rand_float());
    wait_drained();
  endtask

  // Half-precision layout out of reset: zeros, rounding, threshold, overflow,
  // infinities and NaNs
  task automatic test_reset_format();
    logic [31:0] vecs [0:24] = '{
      32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0080_0000, 32'h3F80_0000,
      32'h3F80_1000, 32'hBFFF_F000, 32'h477F_E000, 32'h477F_F000, 32'h4780_0000,
      32'hC800_0000, 32'h7F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
      32'h7F80_0001, 32'h3800_0000, 32'h387F_F000, 32'hB800_1000, 32'h3780_0000,
      32'h37FF_FFFF, 32'h3380_0000, 32'h3300_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF
    };
    foreach (vecs[i]) send_float(vecs[i]);
    wait_drained();
  endtask

  // A write past the register map must leave the format alone
  task automatic test_unmapped_register();
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    repeat (10) send_float(rand_float());
    wait_drained();
  endtask

  task automatic test_narrow_formats();
    run_format(1, 0, -126, 75);
    run_format(2, 1, -1, 75);
    run_format(4, 3, -7, 75);
  endtask

  task automatic test_wide_formats();
    run_format(8, 22, 127, 75);
    run_format(8, 22, -126, 75);
    run_format(5, 2, -15, 75);
  endtask

  // Zero exponent width, significand wider than the single's fraction,
  // sign past bit 31
  task automatic test_out_of_range_widths();
    run_format(0, 0, 0, 75);
    run_format(15, 31, -128, 75);
    run_format(3, 23, 5, 75);
    run_format(8, 31, 127, 75);
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    run_format(EXP_BITS_RST, SIG_BITS_RST, DENORM_BIAS_RST, 250);
  endtask

  initial begin
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_if.valid      <= 1'b0;
    in_if.float_bits <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_format();
    test_unmapped_register();
    test_narrow_formats();
    test_wide_formats();
    test_out_of_range_widths();
    test_back_to_back();
    repeat (5) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver stalls in bursts, with runs of steady ready between them
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (packed_due_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected item: expected none, actual packed_value 0x%08h",
                   $time, out_if.packed_value);
      end else begin
        want = packed_due_q.pop_front();
        if (out_if.packed_value !== want.packed_value) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: float 0x%08h: expected packed_value 0x%08h, actual 0x%08h",
                     $time, want.float_bits, want.packed_value, out_if.packed_value);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
